/* hdl/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types, codes and helpers for the topology snapshot parser
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    localparam logic [31:0] RESET_MAGIC = 32'h544F_5031;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NODE   = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_LINK   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_NODE   = 2'd0;
    localparam logic [1:0] KIND_LINK   = 2'd1;
    localparam logic [1:0] KIND_LABEL  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // end status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_TRAILING  = 2'd3;

    // record byte positions
    localparam logic [4:0] HDR_LAST_POS   = 5'd7;
    localparam logic [4:0] MAGIC_LAST_POS = 5'd3;
    localparam logic [4:0] NODE_LAST_POS  = 5'd23;
    localparam logic [4:0] LINK_LAST_POS  = 5'd16;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] first_id;
        logic [31:0] second_id;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [15:0] vlan;
        logic [63:0] packet_count;
        logic        operational;
        logic [7:0]  label_length;
        logic [7:0]  label_char;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

    // results produced by one accepted byte, packed from slot a upwards
    typedef struct packed {
        logic [1:0] count;
        result_t    slot_a;
        result_t    slot_b;
    } push_t;

    // phase that follows a finished header or record
    function automatic logic [2:0] next_phase(input logic [15:0] nodes,
                                              input logic [15:0] links);
        logic [2:0] ph;
        if (nodes != 16'd0)
            ph = PH_NODE;
        else if (links != 16'd0)
            ph = PH_LINK;
        else
            ph = PH_DONE;
        return ph;
    endfunction

endpackage

`default_nettype wire

/* hdl/tsp_decoder.sv */
// ----------------------------------------------------------------------------
// tsp_decoder
// byte-wise field assembly, record completion and end status
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_decoder (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire tsp_pkg::in_t   word,
    input  wire logic           cfg_we,
    input  wire logic [31:0]    cfg_wdata,
    output tsp_pkg::push_t      push
);

    logic [31:0] magic_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [15:0] nodes_reg, nodes_next;
    logic [15:0] links_reg, links_next;
    logic [31:0] word_a_reg, word_a_next;
    logic [31:0] word_b_reg, word_b_next;
    logic [31:0] coord_x_reg, coord_x_next;
    logic [31:0] coord_y_reg, coord_y_next;
    logic [15:0] vlan_reg, vlan_next;
    logic [8:0]  flag_len_reg, flag_len_next;
    logic [63:0] packets_reg, packets_next;
    logic [7:0]  label_left_reg, label_left_next;
    logic [1:0]  error_reg, error_next;

    logic                 has_rec;
    tsp_pkg::result_t     rec;
    tsp_pkg::result_t     stat;
    logic [7:0]           b;

    assign b = word.data_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        nodes_next      = nodes_reg;
        links_next      = links_reg;
        word_a_next     = word_a_reg;
        word_b_next     = word_b_reg;
        coord_x_next    = coord_x_reg;
        coord_y_next    = coord_y_reg;
        vlan_next       = vlan_reg;
        flag_len_next   = flag_len_reg;
        packets_next    = packets_reg;
        label_left_next = label_left_reg;
        error_next      = error_reg;
        has_rec         = 1'b0;
        rec             = '0;
        stat            = '0;

        case (phase_reg)
            tsp_pkg::PH_HEADER:
            begin
                if (pos_reg < 5'd4)
                    word_a_next = {word_a_reg[23:0], b};
                else if (pos_reg < 5'd6)
                    nodes_next = {nodes_reg[7:0], b};
                else
                    links_next = {links_reg[7:0], b};
                if (pos_reg == tsp_pkg::MAGIC_LAST_POS && word_a_next != magic_reg)
                begin
                    error_next = tsp_pkg::ST_BAD_MAGIC;
                    phase_next = tsp_pkg::PH_ERROR;
                end
                else if (pos_reg == tsp_pkg::HDR_LAST_POS)
                begin
                    pos_next   = 5'd0;
                    phase_next = tsp_pkg::next_phase(nodes_next, links_next);
                end
                else
                    pos_next = pos_reg + 5'd1;
            end
            tsp_pkg::PH_NODE:
            begin
                if (pos_reg < 5'd4)
                    word_a_next = {word_a_reg[23:0], b};
                else if (pos_reg < 5'd8)
                    coord_x_next = {coord_x_reg[23:0], b};
                else if (pos_reg < 5'd12)
                    coord_y_next = {coord_y_reg[23:0], b};
                else if (pos_reg < 5'd14)
                    vlan_next = {vlan_reg[7:0], b};
                else if (pos_reg == 5'd14)
                    flag_len_next = {b[0], flag_len_reg[7:0]};
                else if (pos_reg == 5'd15)
                    flag_len_next = {flag_len_reg[8], b};
                else
                    packets_next = {packets_reg[55:0], b};
                if (pos_reg == tsp_pkg::NODE_LAST_POS)
                begin
                    has_rec              = 1'b1;
                    rec.kind             = tsp_pkg::KIND_NODE;
                    rec.first_id         = word_a_reg;
                    rec.x_bits           = coord_x_reg;
                    rec.y_bits           = coord_y_reg;
                    rec.vlan             = vlan_reg;
                    rec.packet_count     = packets_next;
                    rec.operational      = flag_len_reg[8];
                    rec.label_length     = flag_len_reg[7:0];
                    nodes_next           = nodes_reg - 16'd1;
                    label_left_next      = flag_len_reg[7:0];
                    pos_next             = 5'd0;
                    if (flag_len_reg[7:0] != 8'd0)
                        phase_next = tsp_pkg::PH_LABEL;
                    else
                        phase_next = tsp_pkg::next_phase(nodes_next, links_reg);
                end
                else
                    pos_next = pos_reg + 5'd1;
            end
            tsp_pkg::PH_LABEL:
            begin
                has_rec          = 1'b1;
                rec.kind         = tsp_pkg::KIND_LABEL;
                rec.label_char   = b;
                label_left_next  = label_left_reg - 8'd1;
                if (label_left_next == 8'd0)
                begin
                    pos_next   = 5'd0;
                    phase_next = tsp_pkg::next_phase(nodes_reg, links_reg);
                end
            end
            tsp_pkg::PH_LINK:
            begin
                if (pos_reg < 5'd4)
                    word_a_next = {word_a_reg[23:0], b};
                else if (pos_reg < 5'd8)
                    word_b_next = {word_b_reg[23:0], b};
                else if (pos_reg < 5'd16)
                    packets_next = {packets_reg[55:0], b};
                if (pos_reg == tsp_pkg::LINK_LAST_POS)
                begin
                    has_rec          = 1'b1;
                    rec.kind         = tsp_pkg::KIND_LINK;
                    rec.first_id     = word_a_reg;
                    rec.second_id    = word_b_reg;
                    rec.packet_count = packets_reg;
                    rec.operational  = b[0];
                    links_next       = links_reg - 16'd1;
                    pos_next         = 5'd0;
                    phase_next       = tsp_pkg::next_phase(nodes_reg, links_next);
                end
                else
                    pos_next = pos_reg + 5'd1;
            end
            tsp_pkg::PH_DONE:
            begin
                error_next = tsp_pkg::ST_TRAILING;
                phase_next = tsp_pkg::PH_ERROR;
            end
            default:
            begin
            end
        endcase

        stat.kind        = tsp_pkg::KIND_STATUS;
        stat.last_of_run = 1'b1;
        if (error_next != tsp_pkg::ST_OK)
            stat.status = error_next;
        else if (phase_next == tsp_pkg::PH_DONE)
            stat.status = tsp_pkg::ST_OK;
        else
            stat.status = tsp_pkg::ST_TRUNCATED;

        // end of snapshot, back to a clean header phase
        if (word.is_last)
        begin
            phase_next      = tsp_pkg::PH_HEADER;
            pos_next        = '0;
            nodes_next      = '0;
            links_next      = '0;
            word_a_next     = '0;
            word_b_next     = '0;
            coord_x_next    = '0;
            coord_y_next    = '0;
            vlan_next       = '0;
            flag_len_next   = '0;
            packets_next    = '0;
            label_left_next = '0;
            error_next      = tsp_pkg::ST_OK;
        end

        rec.last_of_run = ~word.is_last;

        push = '0;
        if (has_rec)
        begin
            push.slot_a = rec;
            push.slot_b = stat;
            push.count  = word.is_last ? 2'd2 : 2'd1;
        end
        else if (word.is_last)
        begin
            push.slot_a = stat;
            push.count  = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= tsp_pkg::RESET_MAGIC;
        else if (cfg_we)
            magic_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tsp_pkg::PH_HEADER;
            pos_reg        <= '0;
            nodes_reg      <= '0;
            links_reg      <= '0;
            word_a_reg     <= '0;
            word_b_reg     <= '0;
            coord_x_reg    <= '0;
            coord_y_reg    <= '0;
            vlan_reg       <= '0;
            flag_len_reg   <= '0;
            packets_reg    <= '0;
            label_left_reg <= '0;
            error_reg      <= tsp_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            nodes_reg      <= nodes_next;
            links_reg      <= links_next;
            word_a_reg     <= word_a_next;
            word_b_reg     <= word_b_next;
            coord_x_reg    <= coord_x_next;
            coord_y_reg    <= coord_y_next;
            vlan_reg       <= vlan_next;
            flag_len_reg   <= flag_len_next;
            packets_reg    <= packets_next;
            label_left_reg <= label_left_next;
            error_reg      <= error_next;
        end
    end

    // an error code is only ever held in the error phase
    a_error_phase : assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != tsp_pkg::ST_OK) |-> (phase_reg == tsp_pkg::PH_ERROR))
        else $error("error code held outside error phase");

    // the last byte always leaves the parser in a clean header phase
    a_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && word.is_last) |=>
            (phase_reg == tsp_pkg::PH_HEADER && pos_reg == 5'd0 &&
             error_reg == tsp_pkg::ST_OK))
        else $error("state not cleared after last byte");

    // the label phase never runs with nothing left to send
    a_label_left : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsp_pkg::PH_LABEL) |-> (label_left_reg != 8'd0))
        else $error("label phase with empty count");

endmodule

`default_nettype wire

/* hdl/tsp_out_queue.sv */
// ----------------------------------------------------------------------------
// tsp_out_queue
// small result queue, takes up to two words a cycle and sends one while stall is low
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_en,
    input  wire tsp_pkg::push_t   push,
    output logic                  room,
    output logic                  valid,
    input  wire logic             stall,
    output tsp_pkg::result_t      word
);

    localparam int unsigned AW = tsp_pkg::QUEUE_AW;

    tsp_pkg::result_t entry_reg [tsp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW:0]      count_reg, count_next;
    logic             pop;
    logic [1:0]       n_in;

    assign n_in  = push_en ? push.count : 2'd0;
    assign pop   = valid && !stall;
    assign valid = (count_reg != '0);
    assign word  = entry_reg[rd_reg];
    // room for two more words
    assign room  = (count_reg <= (AW+1)'(tsp_pkg::QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_next    = wr_reg + AW'(n_in);
        rd_next    = rd_reg + AW'(pop);
        count_next = count_reg + (AW+1)'(n_in) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
            entry_reg[wr_reg] <= push.slot_a;
        if (n_in == 2'd2)
            entry_reg[AW'(wr_reg + AW'(1))] <= push.slot_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(tsp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        (push_en && push.count != 2'd0) |-> room)
        else $error("push without room");

    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (pop && n_in == 2'd0) |=> (count_reg == $past(count_reg) - (AW+1)'(1)))
        else $error("queue count did not drop on send");

endmodule

`default_nettype wire

/* hdl/topology_snapshot_parser.sv */
// ----------------------------------------------------------------------------
// topology_snapshot_parser
// byte stream parser for topology snapshots: node, label and link
// words out, with an end status on the last byte
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload                direction
//  -------   ---------------------   --------------------   ---------
//  byte      byte_valid/byte_stall   byte_word (in_t)       into block
//  rec       rec_valid/rec_stall     rec_word (result_t)    out of block
//  cfg       cfg_we                  cfg_wdata (magic)      into block
//
//  one byte is taken per cycle while byte_stall is low; its word is written into the queue and leaves in the
//  cycle after at the earliest; the last byte of a snapshot can give two words (record or label, then status),
//  sent one a cycle while rec_stall is low from a four-word queue
//  byte_stall rises while the queue cannot take two more words
//  reset gives the header phase and the default magic word
//  rec_stall only holds words in the queue; parsing continues until it cannot take two more words
//
`default_nettype none

module topology_snapshot_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire tsp_pkg::in_t      byte_word,
    output logic                   rec_valid,
    input  wire logic              rec_stall,
    output tsp_pkg::result_t       rec_word,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata
);

    tsp_pkg::push_t push;
    logic           accept;
    logic           room;

    // a byte is taken only when the queue can hold whatever it produces
    assign byte_stall = ~room;
    assign accept     = byte_valid && room;

    // field assembly and record completion
    tsp_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (byte_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    // result queue decouples the two sides
    tsp_out_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (accept),
        .push    (push),
        .room    (room),
        .valid   (rec_valid),
        .stall   (rec_stall),
        .word    (rec_word)
    );

endmodule

`default_nettype wire

/* tb/tb_topology_snapshot_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_topology_snapshot_parser
// self-checking bench: snapshot byte streams go in, every record, label and
// end-status word coming out is compared with an in-bench parser model
// ----------------------------------------------------------------------------

module tb_topology_snapshot_parser;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PHASE_BYTES    = 320;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             byte_valid = 1'b0;
    logic             byte_stall;
    tsp_pkg::in_t     byte_word  = '0;
    logic             rec_valid;
    logic             rec_stall  = 1'b0;
    tsp_pkg::result_t rec_word;
    logic             cfg_we     = 1'b0;
    logic [31:0]      cfg_wdata  = '0;

    topology_snapshot_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_word   (rec_word),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #5 clk = ~clk;

    // stimulus and expected words
    tsp_pkg::in_t     byte_queue[$];
    tsp_pkg::result_t due_words[$];
    int unsigned pushed_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned errors       = 0;
    int unsigned kind_seen[4];
    int unsigned status_seen[4];

    // idling controls, set per phase
    bit send_idle      = 1'b1;
    bit recv_idle      = 1'b1;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;

    // model of the parser state
    logic [31:0] p_magic;
    logic [2:0]  p_phase;
    logic [4:0]  p_pos;
    logic [15:0] p_nodes;
    logic [15:0] p_links;
    logic [31:0] p_wa;
    logic [31:0] p_wb;
    logic [31:0] p_x;
    logic [31:0] p_y;
    logic [15:0] p_vlan;
    logic [8:0]  p_flag_len;
    logic [63:0] p_pkts;
    logic [7:0]  p_label_left;
    logic [1:0]  p_err;

    task automatic clear_parse();
        p_phase      = tsp_pkg::PH_HEADER;
        p_pos        = '0;
        p_nodes      = '0;
        p_links      = '0;
        p_wa         = '0;
        p_wb         = '0;
        p_x          = '0;
        p_y          = '0;
        p_vlan       = '0;
        p_flag_len   = '0;
        p_pkts       = '0;
        p_label_left = '0;
        p_err        = tsp_pkg::ST_OK;
    endtask

    // pick the next record type, or done when both counts are used up
    task automatic advance_record();
        p_pos = '0;
        if (p_nodes != 16'd0)
            p_phase = tsp_pkg::PH_NODE;
        else if (p_links != 16'd0)
            p_phase = tsp_pkg::PH_LINK;
        else
            p_phase = tsp_pkg::PH_DONE;
    endtask

    // run one accepted byte through the model, queue the words it gives
    task automatic parse_byte(input tsp_pkg::in_t w);
        tsp_pkg::result_t r[2];
        int               n;
        logic [7:0]       b;
        n = 0;
        b = w.data_byte;
        case (p_phase)
            tsp_pkg::PH_HEADER:
            begin
                if (p_pos < 5'd4)
                    p_wa = {p_wa[23:0], b};
                else if (p_pos < 5'd6)
                    p_nodes = {p_nodes[7:0], b};
                else
                    p_links = {p_links[7:0], b};
                if (p_pos == tsp_pkg::MAGIC_LAST_POS && p_wa != p_magic)
                begin
                    p_err   = tsp_pkg::ST_BAD_MAGIC;
                    p_phase = tsp_pkg::PH_ERROR;
                end
                else if (p_pos == tsp_pkg::HDR_LAST_POS)
                    advance_record();
                else
                    p_pos++;
            end
            tsp_pkg::PH_NODE:
            begin
                if (p_pos < 5'd4)
                    p_wa = {p_wa[23:0], b};
                else if (p_pos < 5'd8)
                    p_x = {p_x[23:0], b};
                else if (p_pos < 5'd12)
                    p_y = {p_y[23:0], b};
                else if (p_pos < 5'd14)
                    p_vlan = {p_vlan[7:0], b};
                else if (p_pos == 5'd14)
                    p_flag_len[8] = b[0];
                else if (p_pos == 5'd15)
                    p_flag_len[7:0] = b;
                else
                    p_pkts = {p_pkts[55:0], b};
                if (p_pos == tsp_pkg::NODE_LAST_POS)
                begin
                    r[n]              = '0;
                    r[n].kind         = tsp_pkg::KIND_NODE;
                    r[n].first_id     = p_wa;
                    r[n].x_bits       = p_x;
                    r[n].y_bits       = p_y;
                    r[n].vlan         = p_vlan;
                    r[n].packet_count = p_pkts;
                    r[n].operational  = p_flag_len[8];
                    r[n].label_length = p_flag_len[7:0];
                    n++;
                    p_nodes--;
                    p_label_left = p_flag_len[7:0];
                    if (p_label_left != 8'd0)
                    begin
                        p_phase = tsp_pkg::PH_LABEL;
                        p_pos   = '0;
                    end
                    else
                        advance_record();
                end
                else
                    p_pos++;
            end
            tsp_pkg::PH_LABEL:
            begin
                r[n]            = '0;
                r[n].kind       = tsp_pkg::KIND_LABEL;
                r[n].label_char = b;
                n++;
                p_label_left--;
                if (p_label_left == 8'd0)
                    advance_record();
            end
            tsp_pkg::PH_LINK:
            begin
                if (p_pos < 5'd4)
                    p_wa = {p_wa[23:0], b};
                else if (p_pos < 5'd8)
                    p_wb = {p_wb[23:0], b};
                else if (p_pos < 5'd16)
                    p_pkts = {p_pkts[55:0], b};
                if (p_pos == tsp_pkg::LINK_LAST_POS)
                begin
                    r[n]              = '0;
                    r[n].kind         = tsp_pkg::KIND_LINK;
                    r[n].first_id     = p_wa;
                    r[n].second_id    = p_wb;
                    r[n].packet_count = p_pkts;
                    r[n].operational  = b[0];
                    n++;
                    p_links--;
                    advance_record();
                end
                else
                    p_pos++;
            end
            tsp_pkg::PH_DONE:
            begin
                // byte past the final record
                p_err   = tsp_pkg::ST_TRAILING;
                p_phase = tsp_pkg::PH_ERROR;
            end
            default:
            begin
            end
        endcase
        if (w.is_last)
        begin
            r[n]      = '0;
            r[n].kind = tsp_pkg::KIND_STATUS;
            if (p_err != tsp_pkg::ST_OK)
                r[n].status = p_err;
            else if (p_phase == tsp_pkg::PH_DONE)
                r[n].status = tsp_pkg::ST_OK;
            else
                r[n].status = tsp_pkg::ST_TRUNCATED;
            n++;
            clear_parse();
        end
        if (n > 0)
            r[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            due_words = {due_words, r[i]};
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // driver: offers bytes from the queue, random gaps between words while send_idle is set
    int unsigned send_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_valid <= 1'b0;
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                parse_byte(byte_word);
                accepted_cnt++;
            end
            // payload only moves once the current word has gone
            if (!byte_valid || !byte_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    byte_word  <= byte_queue.pop_front();
                    byte_valid <= 1'b1;
                    if (send_idle && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 7);
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted word and drives the receiver stall
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    always @(posedge clk)
    begin
        tsp_pkg::result_t want;
        if (!rst_n)
            rec_stall <= 1'b0;
        else
        begin
            if (rec_valid && !rec_stall)
            begin
                kind_seen[rec_word.kind]++;
                if (rec_word.kind == tsp_pkg::KIND_STATUS)
                    status_seen[rec_word.status]++;
                if (due_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %0h",
                             $time, rec_word);
                end
                else
                begin
                    want = due_words.pop_front();
                    check_field("kind", want.kind, rec_word.kind);
                    check_field("first_id", want.first_id, rec_word.first_id);
                    check_field("second_id", want.second_id, rec_word.second_id);
                    check_field("x_bits", want.x_bits, rec_word.x_bits);
                    check_field("y_bits", want.y_bits, rec_word.y_bits);
                    check_field("vlan", want.vlan, rec_word.vlan);
                    check_field("packet_count", want.packet_count,
                                rec_word.packet_count);
                    check_field("operational", want.operational,
                                rec_word.operational);
                    check_field("label_length", want.label_length,
                                rec_word.label_length);
                    check_field("label_char", want.label_char, rec_word.label_char);
                    check_field("status", want.status, rec_word.status);
                    check_field("last_of_run", want.last_of_run,
                                rec_word.last_of_run);
                end
            end
            // one long hold so the output queue fills and the input backs up
            if (hold_left != 0)
            begin
                hold_left--;
                rec_stall <= 1'b1;
            end
            else if (pressure_armed && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                rec_stall    <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                rec_stall <= 1'b1;
            end
            else if (recv_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                rec_stall <= 1'b1;
            end
            else
                rec_stall <= 1'b0;
        end
    end

    // watchdog: too long without any word moving on either side
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (rec_valid && !rec_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        tsp_pkg::in_t w;
        w.data_byte = b;
        w.is_last   = last;
        byte_queue  = {byte_queue, w};
        pushed_cnt++;
    endtask

    // random byte leaning towards the extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = $urandom_range(0, 255);
        endcase
        return b;
    endfunction

    // header, then up to three of each record, optional cut and tail bytes
    task automatic add_snapshot(input logic [31:0] magic, input logic [15:0] nodes,
                                input logic [15:0] links, input int cut,
                                input int extra);
        logic [7:0] s[$];
        int         lab;
        int         gen_nodes;
        int         gen_links;
        s = {s, magic[31:24]};
        s = {s, magic[23:16]};
        s = {s, magic[15:8]};
        s = {s, magic[7:0]};
        s = {s, nodes[15:8]};
        s = {s, nodes[7:0]};
        s = {s, links[15:8]};
        s = {s, links[7:0]};
        gen_nodes = (nodes > 3) ? 3 : nodes;
        gen_links = (links > 3) ? 3 : links;
        for (int i = 0; i < gen_nodes; i++)
        begin
            lab = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 5);
            for (int k = 0; k < 15; k++)
                s = {s, pick_byte()};
            s = {s, lab[7:0]};
            for (int k = 0; k < 8 + lab; k++)
                s = {s, pick_byte()};
        end
        for (int i = 0; i < gen_links; i++)
            for (int k = 0; k < 17; k++)
                s = {s, pick_byte()};
        if (cut > 0 && cut < s.size())
            s = s[0:cut-1];
        for (int k = 0; k < extra; k++)
            s = {s, pick_byte()};
        for (int k = 0; k < s.size(); k++)
            add_byte(s[k], k == s.size() - 1);
    endtask

    // mostly well-formed snapshots, the rest broken or plain noise
    task automatic add_random_snapshot();
        int          mode;
        int          len;
        logic [15:0] nn;
        logic [15:0] nl;
        logic [31:0] bad;
        mode = $urandom_range(0, 99);
        nn   = $urandom_range(0, 3);
        nl   = $urandom_range(0, 3);
        if (mode < 65)
            add_snapshot(p_magic, nn, nl, 0, 0);
        else if (mode < 77)
        begin
            if ($urandom_range(0, 3) == 0)
                nn = $urandom_range(0, 65535);
            add_snapshot(p_magic, nn, nl, $urandom_range(1, 8 + nn * 30 + nl * 17), 0);
        end
        else if (mode < 85)
            add_snapshot(p_magic, nn, nl, 0, $urandom_range(1, 4));
        else if (mode < 93)
        begin
            // one flipped bit, or a whole random word
            bad = ($urandom_range(0, 1) == 0) ? (p_magic ^ (32'd1 << $urandom_range(0, 31)))
                                              : $urandom;
            if (bad == p_magic)
                bad = ~p_magic;
            add_snapshot(bad, nn, nl, $urandom_range(0, 1) ? $urandom_range(4, 12) : 0, 0);
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                add_byte(pick_byte(), k == len - 1);
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = pushed_cnt + count;
        while (pushed_cnt < stop_at)
            add_random_snapshot();
    endtask

    // block is idle once every byte is in and every word has come out
    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        p_magic  = value;
    endtask

    initial
    begin
        p_magic = tsp_pkg::RESET_MAGIC;
        clear_parse();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty snapshot, bad magic, single-byte truncation, tail byte
        add_snapshot(tsp_pkg::RESET_MAGIC, 16'd0, 16'd0, 0, 0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_snapshot(tsp_pkg::RESET_MAGIC, 16'd0, 16'd0, 0, 1);
        wait_idle();

        // all-zero magic, idling on both sides
        write_magic(32'h0000_0000);
        run_random(PHASE_BYTES);
        wait_idle();

        // all-ones magic, receiver always ready
        recv_idle = 1'b0;
        write_magic(32'hFFFF_FFFF);
        run_random(PHASE_BYTES);
        wait_idle();

        // random magic with the long receiver hold
        recv_idle = 1'b1;
        write_magic($urandom);
        run_random(PHASE_BYTES);
        pressure_armed = 1'b1;
        wait_idle();

        // default magic again, full rate on both sides
        send_idle = 1'b0;
        recv_idle = 1'b0;
        write_magic(tsp_pkg::RESET_MAGIC);
        run_random(PHASE_BYTES);
        wait_idle();
        repeat (20) @(posedge clk);

        $display("covered %0d bytes in %0d snapshots under four magic words",
                 accepted_cnt, kind_seen[tsp_pkg::KIND_STATUS]);
        $write("words: %0d node, %0d link, %0d label; ",
               kind_seen[tsp_pkg::KIND_NODE], kind_seen[tsp_pkg::KIND_LINK],
               kind_seen[tsp_pkg::KIND_LABEL]);
        $display("ends: %0d ok, %0d bad magic, %0d truncated, %0d trailing",
                 status_seen[tsp_pkg::ST_OK], status_seen[tsp_pkg::ST_BAD_MAGIC],
                 status_seen[tsp_pkg::ST_TRUNCATED], status_seen[tsp_pkg::ST_TRAILING]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tsp_pkg.sv
hdl/tsp_decoder.sv
hdl/tsp_out_queue.sv
hdl/topology_snapshot_parser.sv
tb/tb_topology_snapshot_parser.sv
